[rtl/cbrl_pkg.sv]
package cbrl_pkg;

   localparam int IN_ROWS     = 16;
   localparam int IN_COLS     = 16;
   localparam int IN_CHANNELS = 8;
   localparam int OUT_FILTERS = 16;
   localparam int KERNEL_ROWS = 3;
   localparam int KERNEL_COLS = 3;

   localparam int TAPS       = KERNEL_ROWS * KERNEL_COLS * IN_CHANNELS;
   localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int LINE_DEPTH = KERNEL_ROWS * IN_COLS * IN_CHANNELS;
   localparam int LINE_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int ROW_W      = $clog2(IN_ROWS);
   localparam int COL_W      = $clog2(IN_COLS);
   localparam int CH_W       = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int FIL_W      = (OUT_FILTERS > 1) ? $clog2(OUT_FILTERS) : 1;
   localparam int KR_W       = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
   localparam int KC_W       = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
   localparam int ACC_W      = 32 + TAP_W + 2;

   localparam logic [1:0] ACT_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_BIAS   = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic [TAP_W-1:0]   tap;
      logic signed [15:0] sample;
   } link_type;

endpackage

[rtl/cbrl_cell.sv]
module cbrl_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  cbrl_pkg::link_type                  link_in,
   output cbrl_pkg::link_type                  link_out,
   input  logic                                wr_en,
   input  logic [cbrl_pkg::TAP_W-1:0]          wr_tap,
   input  logic signed [15:0]                  wr_data,
   output logic signed [cbrl_pkg::ACC_W-1:0]   acc_out,
   output logic                                done_out
);

   logic signed [15:0] wmem [cbrl_pkg::TAPS];

   cbrl_pkg::link_type fwd_ff;
   logic signed [15:0] w_ff, s_ff;
   logic               v1_ff, f1_ff, l1_ff;
   logic signed [31:0] p_ff;
   logic               v2_ff, f2_ff, l2_ff;
   logic signed [cbrl_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic               done_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_tap] <= wr_data;
      end
      w_ff <= wmem[link_in.tap];
   end

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         acc_in = f2_ff ? cbrl_pkg::ACC_W'(p_ff) : acc_ff + cbrl_pkg::ACC_W'(p_ff);
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff.first  <= link_in.first;
      fwd_ff.last   <= link_in.last;
      fwd_ff.tap    <= link_in.tap;
      fwd_ff.sample <= link_in.sample;
      s_ff   <= link_in.sample;
      f1_ff  <= link_in.first;
      l1_ff  <= link_in.last;
      p_ff   <= w_ff * s_ff;
      f2_ff  <= f1_ff;
      l2_ff  <= l1_ff;
      acc_ff <= acc_in;
      if (reset) begin
         fwd_ff.valid <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         fwd_ff.valid <= link_in.valid;
         v1_ff        <= link_in.valid;
         v2_ff        <= v1_ff;
         done_ff      <= v2_ff & l2_ff;
      end
   end

   assign link_out = fwd_ff;
   assign acc_out  = acc_ff;
   assign done_out = done_ff;

endmodule

[rtl/conv2d_bias_relu_layer.sv]
// Multi-channel valid 3x3 convolution with per-filter bias and ReLU, Q8.8.
// Input channel (req_*): one beat per weight load, bias load or feature-map
// sample; samples arrive in raster order with channels innermost.
// Loads and samples that close no window leave the block idle, req_ready high.
// A sample that closes a window starts a pass: the tap sequencer reads the
// line store once per cycle for each of the 72 taps (kernel rows x cols x
// channels), feeding a chain of 16 MAC cells, one per filter, each cell
// registering the sample before passing it to its neighbor. After the chain
// drains (through the 16 cells and the 3-stage cell pipe) the 16 filter
// results leave on rsp_* in ascending filter order, one per cycle while the
// receiver keeps up, through a registered bias/ReLU stage.
// So a closing sample holds req_ready low until the last result beat is
// loaded into the output register.
// When the receiver stalls, the output register holds the beat and the
// result walk waits; nothing is dropped.
// Reset clears the position counters, pass state and valid flags; weight,
// bias and line stores hold garbage until written.
module conv2d_bias_relu_layer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_kernel_row,
   input  logic [1:0]         req_kernel_col,
   input  logic [2:0]         req_in_channel,
   input  logic [3:0]         req_out_filter,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_output_value,
   output logic [3:0]         rsp_out_row,
   output logic [3:0]         rsp_out_col,
   output logic [3:0]         rsp_filter_index,
   output logic               rsp_last_of_run
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam int NF = cbrl_pkg::OUT_FILTERS;
   localparam int AW = cbrl_pkg::ACC_W;

   logic [1:0] state_ff, state_in;

   logic [cbrl_pkg::ROW_W-1:0] row_ff, row_in, orow_ff, orow_in;
   logic [cbrl_pkg::COL_W-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [cbrl_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic [cbrl_pkg::KR_W-1:0]  slot_ff, slot_in;

   // tap sequencer
   logic [cbrl_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic [cbrl_pkg::CH_W-1:0]  tch_ff, tch_in;
   logic [cbrl_pkg::KC_W-1:0]  twc_ff, twc_in;
   logic [cbrl_pkg::KR_W-1:0]  tslot_ff, tslot_in;

   logic [cbrl_pkg::FIL_W-1:0] fil_ff, fil_in;

   logic signed [15:0] line_mem [cbrl_pkg::LINE_DEPTH];
   logic signed [15:0] bias_ff [NF];

   logic                       accept, is_sample, is_weight, is_bias, closes;
   logic                       weight_ok;
   logic [cbrl_pkg::TAP_W-1:0] wr_tap;
   logic [cbrl_pkg::LINE_W-1:0] wr_addr, rd_addr;
   logic                       issue;

   cbrl_pkg::link_type lead_ff;
   cbrl_pkg::link_type link [NF+1];
   logic signed [AW-1:0] acc [NF];
   logic [NF-1:0]        done;

   logic rsp_valid_ff;
   logic [14:0] rsp_value_ff;
   logic [3:0]  rsp_row_ff, rsp_col_ff, rsp_fil_ff;
   logic        rsp_last_ff;
   logic        rsp_load;
   logic signed [AW-1:0] sum;
   logic signed [AW-1:0] shifted;
   logic [14:0] act;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign is_weight = accept & (req_action == cbrl_pkg::ACT_WEIGHT);
   assign is_bias   = accept & (req_action == cbrl_pkg::ACT_BIAS);
   assign is_sample = accept & (req_action == cbrl_pkg::ACT_SAMPLE);

   assign weight_ok = (int'(req_kernel_row) < cbrl_pkg::KERNEL_ROWS)
                   && (int'(req_kernel_col) < cbrl_pkg::KERNEL_COLS)
                   && (int'(req_in_channel) < cbrl_pkg::IN_CHANNELS)
                   && (int'(req_out_filter) < NF);
   assign wr_tap = cbrl_pkg::TAP_W'((int'(req_kernel_row) * cbrl_pkg::KERNEL_COLS
                   + int'(req_kernel_col)) * cbrl_pkg::IN_CHANNELS + int'(req_in_channel));

   assign wr_addr = cbrl_pkg::LINE_W'((int'(slot_ff) * cbrl_pkg::IN_COLS + int'(col_ff))
                    * cbrl_pkg::IN_CHANNELS + int'(ch_ff));
   assign rd_addr = cbrl_pkg::LINE_W'((int'(tslot_ff) * cbrl_pkg::IN_COLS + int'(ocol_ff)
                    + int'(twc_ff)) * cbrl_pkg::IN_CHANNELS + int'(tch_ff));

   assign closes = (int'(ch_ff) == cbrl_pkg::IN_CHANNELS - 1)
                && (int'(row_ff) >= cbrl_pkg::KERNEL_ROWS - 1)
                && (int'(col_ff) >= cbrl_pkg::KERNEL_COLS - 1);

   assign issue = (state_ff == ST_MAC);

   // window start slot is the row after the newest one, modulo kernel rows
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      ch_in    = ch_ff;
      slot_in  = slot_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      tap_in   = tap_ff;
      tch_in   = tch_ff;
      twc_in   = twc_ff;
      tslot_in = tslot_ff;
      state_in = state_ff;
      fil_in   = fil_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_sample) begin
               if (closes) begin
                  orow_in  = cbrl_pkg::ROW_W'(int'(row_ff) - (cbrl_pkg::KERNEL_ROWS - 1));
                  ocol_in  = cbrl_pkg::COL_W'(int'(col_ff) - (cbrl_pkg::KERNEL_COLS - 1));
                  tslot_in = (int'(slot_ff) == cbrl_pkg::KERNEL_ROWS - 1)
                             ? '0 : cbrl_pkg::KR_W'(int'(slot_ff) + 1);
                  tap_in   = '0;
                  tch_in   = '0;
                  twc_in   = '0;
                  state_in = ST_MAC;
               end
               if (int'(ch_ff) == cbrl_pkg::IN_CHANNELS - 1) begin
                  ch_in = '0;
                  if (int'(col_ff) == cbrl_pkg::IN_COLS - 1) begin
                     col_in  = '0;
                     slot_in = (int'(slot_ff) == cbrl_pkg::KERNEL_ROWS - 1)
                               ? '0 : cbrl_pkg::KR_W'(int'(slot_ff) + 1);
                     if (int'(row_ff) == cbrl_pkg::IN_ROWS - 1) begin
                        row_in  = '0;
                        slot_in = '0;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + 1'b1;
            if (int'(tch_ff) == cbrl_pkg::IN_CHANNELS - 1) begin
               tch_in = '0;
               if (int'(twc_ff) == cbrl_pkg::KERNEL_COLS - 1) begin
                  twc_in   = '0;
                  tslot_in = (int'(tslot_ff) == cbrl_pkg::KERNEL_ROWS - 1)
                             ? '0 : cbrl_pkg::KR_W'(int'(tslot_ff) + 1);
               end else begin
                  twc_in = twc_ff + 1'b1;
               end
            end else begin
               tch_in = tch_ff + 1'b1;
            end
            if (int'(tap_ff) == cbrl_pkg::TAPS - 1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            fil_in = '0;
            if (done[NF-1]) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               fil_in = fil_ff + 1'b1;
               if (int'(fil_ff) == NF - 1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      orow_ff  <= orow_in;
      ocol_ff  <= ocol_in;
      tap_ff   <= tap_in;
      tch_ff   <= tch_in;
      twc_ff   <= twc_in;
      tslot_ff <= tslot_in;
      fil_ff   <= fil_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         ch_ff    <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ch_ff    <= ch_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_sample) begin
         line_mem[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (is_bias && (int'(req_out_filter) < NF)) begin
         bias_ff[cbrl_pkg::FIL_W'(req_out_filter)] <= req_value;
      end
   end

   // line store read lands in the lead beat together with its tap
   always_ff @(posedge clock) begin
      lead_ff.first  <= (tap_ff == '0);
      lead_ff.last   <= (int'(tap_ff) == cbrl_pkg::TAPS - 1);
      lead_ff.tap    <= tap_ff;
      lead_ff.sample <= line_mem[rd_addr];
      if (reset) begin
         lead_ff.valid <= 1'b0;
      end else begin
         lead_ff.valid <= issue;
      end
   end

   assign link[0] = lead_ff;

   for (genvar i = 0; i < NF; i++) begin : g_cell
      cbrl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .wr_en    (is_weight && weight_ok && (int'(req_out_filter) == i)),
         .wr_tap   (wr_tap),
         .wr_data  (req_value),
         .acc_out  (acc[i]),
         .done_out (done[i])
      );
   end

   assign sum     = acc[fil_ff] + (AW'(bias_ff[fil_ff]) <<< 8);
   assign shifted = sum >>> 8;
   always_comb begin
      if (sum <= 0) begin
         act = '0;
      end else if (shifted > AW'(32767)) begin
         act = 15'h7fff;
      end else begin
         act = shifted[14:0];
      end
   end

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= act;
         rsp_row_ff   <= 4'(orow_ff);
         rsp_col_ff   <= 4'(ocol_ff);
         rsp_fil_ff   <= 4'(fil_ff);
         rsp_last_ff  <= (int'(fil_ff) == NF - 1);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_filter_index = rsp_fil_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done[NF-1] |-> (state_ff == ST_DRAIN))
      else $error("last cell finished outside drain");

   a_last_filter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> (int'(rsp_filter_index) == NF - 1))
      else $error("last_of_run on wrong filter");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |=> !accept || (state_ff == ST_IDLE))
      else $error("beat taken during a pass");

endmodule
